// File: rtl/mpq_pkg.sv
// Shared types and constants for the pair max-priority queue.
`default_nettype none

package mpq_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic cmp;
    logic apply;
    op_e  op;
  } mpq_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mpq_cell.sv
// One cell of the sorted chain: holds a pair and shifts with its neighbours.
`default_nettype none

module mpq_cell import mpq_pkg::*; #(
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mpq_ctrl_t               ctrl_i,
  input  wire logic [2*KEY_BITS-1:0]   key_i,
  input  wire logic                    left_ge_i,
  input  wire logic [2*KEY_BITS-1:0]   left_key_i,
  input  wire logic                    left_valid_i,
  input  wire logic [2*KEY_BITS-1:0]   right_key_i,
  input  wire logic                    right_valid_i,
  input  wire logic                    found_i,
  output logic      [2*KEY_BITS-1:0]   key_o,
  output logic                         valid_o,
  output logic                         gt_o,
  output logic                         eq_o
);

  logic [2*KEY_BITS-1:0] key_q, key_d;
  logic                  valid_q, valid_d;
  logic                  gt_q, eq_q;
  logic                  ge;

  assign ge = gt_q | eq_q;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.apply) begin
      case (ctrl_i.op)
        OP_INSERT: begin
          // Entries not below the new pair stay; the first smaller one
          // takes the new pair and the rest move one place down.
          if (!ge) begin
            if (left_ge_i) begin
              key_d   = key_i;
              valid_d = 1'b1;
            end else begin
              key_d   = left_key_i;
              valid_d = left_valid_i;
            end
          end
        end
        OP_REMOVE: begin
          if (found_i && !gt_q) begin
            key_d   = right_key_i;
            valid_d = right_valid_i;
          end
        end
        OP_POP: begin
          key_d   = right_key_i;
          valid_d = right_valid_i;
        end
        default: begin
          key_d   = key_q;
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp) begin
        gt_q <= valid_q && (key_q > key_i);
        eq_q <= valid_q && (key_q == key_i);
      end
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign gt_o    = gt_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

// File: rtl/max_priority_queue_pairs.sv
// A result is registered as its item leaves the apply state, once the output
// register is free. A new item is taken only after the last one has left the
// apply state; each item is compared against every cell when it is accepted,
// and the chain shifts when it is applied.
// Reset empties the queue at once by clearing each cell's valid bit; stored
// pairs are not cleared and no clearing pass is needed.
// Top level of the pair max-priority queue built as a sorted chain of cells.
`default_nettype none

module max_priority_queue_pairs import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          func_i,
  input  wire logic [FIELD_W-1:0]  key_major_i,
  input  wire logic [FIELD_W-1:0]  key_minor_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [FIELD_W-1:0]       out_major_o,
  output logic [FIELD_W-1:0]       out_minor_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [COUNT_W-1:0]       entry_count_o,
  output logic                     is_empty_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = 2 * KEY_BITS;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [KW-1:0]       key_q, in_key, cell_key_in;
  op_e                 op_q;
  logic [CW-1:0]       count_q, count_d;
  logic                out_valid_q;
  logic [FIELD_W-1:0]  out_major_q, out_minor_q;
  status_e             status_q, status_d;
  logic [COUNT_W-1:0]  entry_count_q;
  logic                is_empty_q;

  logic [KW-1:0]       cell_key [CAPACITY];
  logic [CAPACITY-1:0] valid_vec, gt_vec, eq_vec, ge_vec;
  logic                found, full, empty, accept, fire, allowed, pop_ok;
  mpq_ctrl_t           ctrl;

  assign in_key = {key_major_i[KEY_BITS-1:0], key_minor_i[KEY_BITS-1:0]};
  assign accept = in_valid_i && in_ready_o;
  assign fire   = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cell_key_in = (state_q == S_IDLE) ? in_key : key_q;

  assign ge_vec = gt_vec | eq_vec;
  // In a descending chain the first cell not above the key is the only
  // place where a match can start.
  assign found  = |(eq_vec & {gt_vec[CAPACITY-2:0], 1'b1});
  assign full   = (count_q == CW'(CAPACITY));
  assign empty  = !valid_vec[0];
  assign pop_ok = (op_q == OP_POP) && !empty;

  always_comb begin
    allowed  = 1'b0;
    status_d = ST_OK;
    count_d  = count_q;
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          allowed = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      OP_REMOVE: begin
        allowed = 1'b1;
        if (found) begin
          count_d = count_q - CW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          allowed = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        allowed = 1'b0;
      end
    endcase
  end

  assign ctrl.cmp   = accept;
  assign ctrl.apply = fire && allowed;
  assign ctrl.op    = op_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KW-1:0] left_key, right_key;
    logic          left_valid, right_valid, left_ge;

    if (i == 0) begin : g_head
      assign left_key   = cell_key_in;
      assign left_valid = 1'b0;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_key   = cell_key[i-1];
      assign left_valid = valid_vec[i-1];
      assign left_ge    = ge_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key   = cell_key[i];
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_key   = cell_key[i+1];
      assign right_valid = valid_vec[i+1];
    end

    mpq_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (cell_key_in),
      .left_ge_i    (left_ge),
      .left_key_i   (left_key),
      .left_valid_i (left_valid),
      .right_key_i  (right_key),
      .right_valid_i(right_valid),
      .found_i      (found),
      .key_o        (cell_key[i]),
      .valid_o      (valid_vec[i]),
      .gt_o         (gt_vec[i]),
      .eq_o         (eq_vec[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_APPLY;
      S_APPLY: if (fire)   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_key;
      op_q  <= op_e'(func_i);
    end
    if (fire) begin
      out_major_q   <= pop_ok ? FIELD_W'(cell_key[0][KW-1 -: KEY_BITS]) : '0;
      out_minor_q   <= pop_ok ? FIELD_W'(cell_key[0][KEY_BITS-1:0]) : '0;
      status_q      <= status_d;
      entry_count_q <= COUNT_W'(count_d);
      is_empty_q    <= (count_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_major_o   = out_major_q;
  assign out_minor_o   = out_minor_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;
  assign is_empty_o    = is_empty_q;

`ifndef ASSERT_OFF
  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("entry count disagrees with occupied cells");

  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
    else $error("occupied cells are not packed at the head of the chain");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_vec[1] |-> (cell_key[0] >= cell_key[1]))
    else $error("head of the chain is not the largest pair");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("a second item was taken while one is still in work");

  a_result_after_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("finished item produced no result");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the pair max-priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import mpq_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_BITS = 32;
  localparam logic [FIELD_W-1:0] KEY_MASK =
      (KEY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << KEY_BITS) - 32'd1);
  localparam logic [FIELD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct packed {
    logic [FIELD_W-1:0] major;
    logic [FIELD_W-1:0] minor;
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } result_t;

  typedef struct {
    op_e                op;
    logic [FIELD_W-1:0] major;
    logic [FIELD_W-1:0] minor;
    bit                 typed;
    result_t            res;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [1:0]          func_i      = 2'd0;
  logic [FIELD_W-1:0]  key_major_i = '0;
  logic [FIELD_W-1:0]  key_minor_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [FIELD_W-1:0]  out_major_o;
  logic [FIELD_W-1:0]  out_minor_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic                is_empty_o;

  // Pairs the queue should hold, in no particular order, and the results still owed.
  logic [63:0] held_pairs[$];
  result_t     expected_q[$];
  row_t        directed_rows[$];
  int          errors     = 0;
  int          burst_left = 0;

  max_priority_queue_pairs #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .key_major_i  (key_major_i),
    .key_minor_i  (key_minor_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_major_o  (out_major_o),
    .out_minor_o  (out_minor_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic result_t apply_op(input op_e op, input logic [FIELD_W-1:0] major,
                                       input logic [FIELD_W-1:0] minor);
    result_t     r;
    logic [63:0] key;
    int          hit;
    r   = '0;
    key = {major & KEY_MASK, minor & KEY_MASK};
    hit = -1;
    case (op)
      OP_INSERT: begin
        if (held_pairs.size() >= CAPACITY) r.status = ST_FULL;
        else held_pairs.push_back(key);
      end
      OP_REMOVE: begin
        foreach (held_pairs[i]) if (hit < 0 && held_pairs[i] == key) hit = i;
        if (hit < 0) r.status = ST_NOT_FOUND;
        else held_pairs.delete(hit);
      end
      OP_POP: begin
        foreach (held_pairs[i]) if (hit < 0 || held_pairs[i] > held_pairs[hit]) hit = i;
        if (hit < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.major = held_pairs[hit][63:32];
          r.minor = held_pairs[hit][31:0];
          held_pairs.delete(hit);
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(held_pairs.size());
    r.empty = (held_pairs.size() == 0);
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_key_part();
    int sel;
    sel = $urandom_range(0, 99);
    // Small values make ties on the major part and duplicate pairs common.
    if (sel < 30) return FIELD_W'($urandom_range(0, 3));
    if (sel < 36) return '0;
    if (sel < 42) return ALL_ONES;
    return $urandom;
  endfunction

  task automatic add_row(input op_e op, input logic [FIELD_W-1:0] major,
                         input logic [FIELD_W-1:0] minor, input bit typed,
                         input status_e status, input int count,
                         input logic [FIELD_W-1:0] res_major, input logic [FIELD_W-1:0] res_minor);
    row_t row;
    row.op         = op;
    row.major      = major;
    row.minor      = minor;
    row.typed      = typed;
    row.res.major  = res_major;
    row.res.minor  = res_minor;
    row.res.status = status;
    row.res.count  = COUNT_W'(count);
    row.res.empty  = (count == 0);
    directed_rows.push_back(row);
  endtask

  // Offers one item, holds it until it is taken, then records what it should yield.
  task automatic send_item(input op_e op, input logic [FIELD_W-1:0] major,
                           input logic [FIELD_W-1:0] minor, input bit typed,
                           input result_t typed_res);
    result_t pred;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    func_i      <= op;
    key_major_i <= major;
    key_minor_i <= minor;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pred = apply_op(op, major, minor);
    expected_q.push_back(typed ? typed_res : pred);
  endtask

  // Receiver: switches between random stall patterns, with one long hold-off.
  initial begin : receiver
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (cyc >= 2000 && cyc < 2400) begin
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= (cyc % 4 != 0);
          default: out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(negedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with no item waiting: major %h minor %h status %0d count %0d",
                 $time, out_major_o, out_minor_o, status_o, entry_count_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_major_o !== want.major) begin
          $display("%0t: out_major expected %h actual %h", $time, want.major, out_major_o);
          errors++;
        end
        if (out_minor_o !== want.minor) begin
          $display("%0t: out_minor expected %h actual %h", $time, want.minor, out_minor_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
        if (entry_count_o !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   entry_count_o);
          errors++;
        end
        if (is_empty_o !== want.empty) begin
          $display("%0t: is_empty expected %0d actual %0d", $time, want.empty, is_empty_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          phase;
    int          sel;
    int          pick;
    op_e         op;
    logic [FIELD_W-1:0] major;
    logic [FIELD_W-1:0] minor;

    // Empty queue, extremes of both fields, duplicates and tie-breaking on the minor part.
    add_row(OP_POP,    32'd0,    32'd0,    1'b1, ST_EMPTY,     0, 32'd0, 32'd0);
    add_row(OP_REMOVE, 32'd5,    32'd5,    1'b1, ST_NOT_FOUND, 0, 32'd0, 32'd0);
    add_row(OP_NOP,    ALL_ONES, ALL_ONES, 1'b1, ST_OK,        0, 32'd0, 32'd0);
    add_row(OP_INSERT, 32'd0,    32'd0,    1'b1, ST_OK,        1, 32'd0, 32'd0);
    add_row(OP_INSERT, ALL_ONES, ALL_ONES, 1'b1, ST_OK,        2, 32'd0, 32'd0);
    add_row(OP_INSERT, ALL_ONES, 32'd0,    1'b1, ST_OK,        3, 32'd0, 32'd0);
    add_row(OP_INSERT, 32'd0,    ALL_ONES, 1'b1, ST_OK,        4, 32'd0, 32'd0);
    add_row(OP_INSERT, ALL_ONES, ALL_ONES, 1'b1, ST_OK,        5, 32'd0, 32'd0);
    add_row(OP_POP,    32'd0,    32'd0,    1'b1, ST_OK,        4, ALL_ONES, ALL_ONES);
    add_row(OP_REMOVE, ALL_ONES, ALL_ONES, 1'b1, ST_OK,        3, 32'd0, 32'd0);
    add_row(OP_REMOVE, ALL_ONES, ALL_ONES, 1'b1, ST_NOT_FOUND, 3, 32'd0, 32'd0);
    add_row(OP_POP,    ALL_ONES, ALL_ONES, 1'b1, ST_OK,        2, ALL_ONES, 32'd0);
    add_row(OP_INSERT, 32'd1,    32'd0,    1'b0, ST_OK,        0, 32'd0, 32'd0);
    add_row(OP_INSERT, 32'd0,    32'h8000_0000, 1'b0, ST_OK,   0, 32'd0, 32'd0);
    add_row(OP_POP,    32'd0,    32'd0,    1'b0, ST_OK,        0, 32'd0, 32'd0);
    add_row(OP_NOP,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, ST_OK, 0, 32'd0, 32'd0);
    add_row(OP_REMOVE, 32'd0,    32'd0,    1'b0, ST_OK,        0, 32'd0, 32'd0);
    add_row(OP_POP,    32'd0,    32'd0,    1'b0, ST_OK,        0, 32'd0, 32'd0);
    add_row(OP_POP,    32'd0,    32'd0,    1'b0, ST_OK,        0, 32'd0, 32'd0);
    add_row(OP_POP,    32'd0,    32'd0,    1'b1, ST_EMPTY,     0, 32'd0, 32'd0);
    add_row(OP_REMOVE, 32'd0,    32'd0,    1'b1, ST_NOT_FOUND, 0, 32'd0, 32'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].major, directed_rows[i].minor,
                directed_rows[i].typed, directed_rows[i].res);

    // Phases lean towards filling, draining or churning the queue so that both the
    // full and the empty boundaries are crossed many times.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 150) % 4;
      sel   = $urandom_range(0, 99);
      case (phase)
        0:       op = (sel < 40) ? OP_INSERT : (sel < 65) ? OP_REMOVE :
                      (sel < 97) ? OP_POP : OP_NOP;
        1:       op = (sel < 80) ? OP_INSERT : (sel < 88) ? OP_REMOVE :
                      (sel < 97) ? OP_POP : OP_NOP;
        2:       op = (sel < 45) ? OP_INSERT : (sel < 80) ? OP_REMOVE :
                      (sel < 97) ? OP_POP : OP_NOP;
        default: op = (sel < 15) ? OP_INSERT : (sel < 30) ? OP_REMOVE :
                      (sel < 97) ? OP_POP : OP_NOP;
      endcase
      major = pick_key_part();
      minor = pick_key_part();
      // Most removals name a pair that is actually stored.
      if (op == OP_REMOVE && held_pairs.size() != 0 && $urandom_range(0, 3) != 0) begin
        pick  = $urandom_range(0, held_pairs.size() - 1);
        major = held_pairs[pick][63:32];
        minor = held_pairs[pick][31:0];
      end
      send_item(op, major, minor, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
rtl/mpq_pkg.sv
rtl/mpq_cell.sv
rtl/max_priority_queue_pairs.sv
tb/testbench.sv
